>>> rtl/hkst_pkg.sv
`default_nettype none
package hkst_pkg;

	localparam int KEY_W             = 32;
	localparam int VAL_W             = 32;
	localparam int BC_W              = 7;
	localparam int BC_RESET          = 64;
	localparam int DEF_NUM_BUCKETS   = 64;
	localparam int DEF_SLOTS         = 4;
	localparam int DEF_POOL_DEPTH    = 1024;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic                    func;
		logic [KEY_W-1:0]        key;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] popped_value;
		logic [1:0]              status;
	} rsp_t;

	typedef logic [BC_W-1:0] bucket_count_t;

	typedef struct packed {
		logic load;
		logic mod_step;
		logic probe_rd;
		logic probe_cmp;
		logic top_new;
		logic top_rd;
		logic top_ld;
		logic node_ld;
		logic node_rd;
		logic commit_push;
		logic commit_pop;
		logic fail_empty;
		logic fail_full;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		logic mod_done;
		logic probe_last;
		logic func;
		logic found;
		logic free;
		logic pool_has;
		logic top_null;
	} sts_t;

endpackage
`default_nettype wire

>>> rtl/hkst_chan_if.sv
`default_nettype none
interface hkst_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/hashed_key_stack_table_core.sv
`default_nettype none
// Channel  Role    Payload                      Handshake
// req      sink    func, key, value             valid/ready
// rsp      source  popped_value, status         valid/ready
// cfg      sink    bucket_count                 valid/ready (ready always high)
//
// Each item runs the serial key remainder one key bit at a time, then probes the
// bucket through the key memory with a read and a compare per slot, then makes,
// as needed, the pointer and node memory accesses, and the result handoff.
// Reset clears the claimed flags, the free list head and the fresh node count.
// A finished result waits in the output register; a new item is taken while
// it waits, and a further result stalls until that register is taken.
module hashed_key_stack_table_core #(
	parameter int NUM_BUCKETS      = hkst_pkg::DEF_NUM_BUCKETS,
	parameter int SLOTS_PER_BUCKET = hkst_pkg::DEF_SLOTS,
	parameter int POOL_DEPTH       = hkst_pkg::DEF_POOL_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	hkst_chan_if.sink   req,
	hkst_chan_if.source rsp,
	hkst_chan_if.sink   cfg
);
	hkst_pkg::cmd_t cmd;
	hkst_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	hkst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hkst_dp #(
		.NUM_BUCKETS      (NUM_BUCKETS),
		.SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
		.POOL_DEPTH       (POOL_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_data  (req.data),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.data),
		.rsp_data  (rsp.data)
	);
endmodule
`default_nettype wire

>>> rtl/hkst_ram.sv
`default_nettype none
module hkst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   we,
	input  wire logic [AW-1:0]          waddr,
	input  wire logic [WIDTH-1:0]       wdata,
	input  wire logic                   re,
	input  wire logic [AW-1:0]          raddr,
	output      logic [WIDTH-1:0]       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

>>> rtl/hkst_ctrl.sv
`default_nettype none
module hkst_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output      logic          req_ready,
	output      logic          out_valid,
	input  wire logic          out_ready,
	input  wire hkst_pkg::sts_t sts,
	output      hkst_pkg::cmd_t cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_MOD, S_PRB, S_CMP, S_SEL, S_TRD, S_TLD, S_NLD, S_NRD, S_CMT, S_FIN
	} state_t;

	state_t state_q;
	logic   out_free;

	assign out_free  = !out_valid || out_ready;
	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.load = req_valid;
			S_MOD:  cmd.mod_step = 1'b1;
			S_PRB:  cmd.probe_rd = 1'b1;
			S_CMP:  cmd.probe_cmp = 1'b1;
			S_SEL: begin
				if (sts.func == hkst_pkg::FUNC_POP) begin
					cmd.fail_empty = !sts.found;
				end else if (!(sts.found || sts.free) || !sts.pool_has) begin
					cmd.fail_full = 1'b1;
				end else begin
					cmd.top_new = !sts.found;
				end
			end
			S_TRD:  cmd.top_rd = 1'b1;
			S_TLD:  cmd.top_ld = 1'b1;
			S_NLD: begin
				if (sts.func == hkst_pkg::FUNC_POP && sts.top_null) begin
					cmd.fail_empty = 1'b1;
				end else begin
					cmd.node_ld = 1'b1;
				end
			end
			S_NRD:  cmd.node_rd = 1'b1;
			S_CMT: begin
				cmd.commit_push = (sts.func == hkst_pkg::FUNC_PUSH);
				cmd.commit_pop  = (sts.func == hkst_pkg::FUNC_POP);
			end
			S_FIN:  cmd.out_ld = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (cmd.out_ld) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (req_valid) state_q <= S_MOD;
				S_MOD:  if (sts.mod_done) state_q <= S_PRB;
				S_PRB:  state_q <= S_CMP;
				S_CMP:  state_q <= sts.probe_last ? S_SEL : S_PRB;
				S_SEL: begin
					if (cmd.fail_empty || cmd.fail_full) begin
						state_q <= S_FIN;
					end else if (cmd.top_new) begin
						state_q <= S_NLD;
					end else begin
						state_q <= S_TRD;
					end
				end
				S_TRD:  state_q <= S_TLD;
				S_TLD:  state_q <= S_NLD;
				S_NLD:  state_q <= cmd.fail_empty ? S_FIN : S_NRD;
				S_NRD:  state_q <= S_CMT;
				S_CMT:  state_q <= S_FIN;
				S_FIN:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> rtl/hkst_dp.sv
`default_nettype none
module hkst_dp #(
	parameter int NUM_BUCKETS      = hkst_pkg::DEF_NUM_BUCKETS,
	parameter int SLOTS_PER_BUCKET = hkst_pkg::DEF_SLOTS,
	parameter int POOL_DEPTH       = hkst_pkg::DEF_POOL_DEPTH
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire hkst_pkg::cmd_t          cmd,
	output      hkst_pkg::sts_t          sts,
	input  wire hkst_pkg::req_t          req_data,
	input  wire logic                    cfg_valid,
	input  wire hkst_pkg::bucket_count_t cfg_data,
	output      hkst_pkg::rsp_t          rsp_data
);
	localparam int SLOT_TOTAL = NUM_BUCKETS * SLOTS_PER_BUCKET;
	localparam int SLOT_AW    = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
	localparam int IDX_W      = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
	localparam int PTR_W      = $clog2(POOL_DEPTH + 1);
	localparam int NODE_AW    = $clog2(POOL_DEPTH);
	localparam int KW         = hkst_pkg::KEY_W;
	localparam int VW         = hkst_pkg::VAL_W;
	localparam int BW         = hkst_pkg::BC_W;
	localparam int CNT_W      = $clog2(KW);
	localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_DEPTH);

	hkst_pkg::bucket_count_t bucket_count_q;
	logic                    func_q;
	logic [KW-1:0]           key_q, shift_q;
	logic [VW-1:0]           value_q;
	logic [BW-1:0]           rem_q, divisor;
	logic [BW:0]             rem_sh;
	logic [CNT_W-1:0]        bit_cnt_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    found_q, free_q;
	logic [SLOT_AW-1:0]      found_slot_q, free_slot_q, probe_slot, sel_slot;
	logic [SLOT_TOTAL-1:0]   claimed_q;
	logic [PTR_W-1:0]        top_q, node_q, free_top_q, fresh_q;
	logic [VW-1:0]           res_popped_q;
	logic [1:0]              res_status_q;
	hkst_pkg::rsp_t          out_q;

	logic [KW-1:0]    key_rd;
	logic [PTR_W-1:0] top_rd, link_rd;
	logic [VW-1:0]    val_rd;
	logic             link_we;
	logic [PTR_W-1:0] link_wdata;

	always_comb begin
		if (bucket_count_q == '0) begin
			divisor = BW'(1);
		end else if (32'(bucket_count_q) > NUM_BUCKETS) begin
			divisor = BW'(NUM_BUCKETS);
		end else begin
			divisor = bucket_count_q;
		end
	end

	// Restoring remainder step, one key bit per cycle from the top.
	always_comb begin
		rem_sh = {rem_q, shift_q[KW-1]};
		if (rem_sh >= {1'b0, divisor}) begin
			rem_sh = rem_sh - {1'b0, divisor};
		end
	end

	assign probe_slot = SLOT_AW'(32'(rem_q) * SLOTS_PER_BUCKET + 32'(idx_q));
	assign sel_slot   = found_q ? found_slot_q : free_slot_q;

	assign sts.mod_done   = (bit_cnt_q == CNT_W'(KW - 1));
	assign sts.probe_last = (32'(idx_q) == SLOTS_PER_BUCKET - 1);
	assign sts.func       = func_q;
	assign sts.found      = found_q;
	assign sts.free       = free_q;
	assign sts.pool_has   = (free_top_q != NULL_PTR) || (fresh_q != NULL_PTR);
	assign sts.top_null   = (top_q == NULL_PTR);

	assign rsp_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BW'(hkst_pkg::BC_RESET);
			claimed_q      <= '0;
			free_top_q     <= NULL_PTR;
			fresh_q        <= '0;
		end else begin
			if (cfg_valid) begin
				bucket_count_q <= cfg_data;
			end
			if (cmd.commit_push) begin
				claimed_q[sel_slot] <= 1'b1;
				if (free_top_q != NULL_PTR) begin
					free_top_q <= link_rd;
				end else begin
					fresh_q <= fresh_q + PTR_W'(1);
				end
			end
			if (cmd.commit_pop) begin
				free_top_q <= node_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q    <= req_data.func;
			key_q     <= req_data.key;
			shift_q   <= req_data.key;
			value_q   <= req_data.value;
			rem_q     <= '0;
			bit_cnt_q <= '0;
			idx_q     <= '0;
			found_q   <= 1'b0;
			free_q    <= 1'b0;
		end
		if (cmd.mod_step) begin
			rem_q     <= rem_sh[BW-1:0];
			shift_q   <= {shift_q[KW-2:0], 1'b0};
			bit_cnt_q <= bit_cnt_q + CNT_W'(1);
		end
		if (cmd.probe_cmp) begin
			if (claimed_q[probe_slot] && key_rd == key_q && !found_q) begin
				found_q      <= 1'b1;
				found_slot_q <= probe_slot;
			end
			if (!claimed_q[probe_slot] && !free_q) begin
				free_q      <= 1'b1;
				free_slot_q <= probe_slot;
			end
			idx_q <= idx_q + IDX_W'(1);
		end
		if (cmd.top_new) begin
			top_q <= NULL_PTR;
		end
		if (cmd.top_ld) begin
			top_q <= top_rd;
		end
		if (cmd.node_ld) begin
			if (func_q == hkst_pkg::FUNC_POP) begin
				node_q <= top_q;
			end else if (free_top_q != NULL_PTR) begin
				node_q <= free_top_q;
			end else begin
				node_q <= fresh_q;
			end
		end
		if (cmd.commit_push) begin
			res_popped_q <= '0;
			res_status_q <= hkst_pkg::STATUS_OK;
		end
		if (cmd.commit_pop) begin
			res_popped_q <= val_rd;
			res_status_q <= hkst_pkg::STATUS_OK;
		end
		if (cmd.fail_empty) begin
			res_popped_q <= '0;
			res_status_q <= hkst_pkg::STATUS_EMPTY;
		end
		if (cmd.fail_full) begin
			res_popped_q <= '0;
			res_status_q <= hkst_pkg::STATUS_FULL;
		end
		if (cmd.out_ld) begin
			out_q.popped_value <= res_popped_q;
			out_q.status       <= res_status_q;
		end
	end

	assign link_we    = cmd.commit_push || cmd.commit_pop;
	assign link_wdata = cmd.commit_pop ? free_top_q : top_q;

	hkst_ram #(.WIDTH(KW), .DEPTH(SLOT_TOTAL)) u_key_ram (
		.clk   (clk),
		.we    (cmd.commit_push),
		.waddr (sel_slot),
		.wdata (key_q),
		.re    (cmd.probe_rd),
		.raddr (probe_slot),
		.rdata (key_rd)
	);

	hkst_ram #(.WIDTH(PTR_W), .DEPTH(SLOT_TOTAL)) u_top_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (sel_slot),
		.wdata (cmd.commit_pop ? link_rd : node_q),
		.re    (cmd.top_rd),
		.raddr (sel_slot),
		.rdata (top_rd)
	);

	hkst_ram #(.WIDTH(VW), .DEPTH(POOL_DEPTH)) u_val_ram (
		.clk   (clk),
		.we    (cmd.commit_push),
		.waddr (node_q[NODE_AW-1:0]),
		.wdata (value_q),
		.re    (cmd.node_rd),
		.raddr (node_q[NODE_AW-1:0]),
		.rdata (val_rd)
	);

	hkst_ram #(.WIDTH(PTR_W), .DEPTH(POOL_DEPTH)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (node_q[NODE_AW-1:0]),
		.wdata (link_wdata),
		.re    (cmd.node_rd),
		.raddr (node_q[NODE_AW-1:0]),
		.rdata (link_rd)
	);
endmodule
`default_nettype wire

>>> test/tb_hashed_key_stack_table_core.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_hashed_key_stack_table_core;
	import hkst_pkg::*;

	localparam int NB = DEF_NUM_BUCKETS;
	localparam int SPB = DEF_SLOTS;
	localparam int PD = DEF_POOL_DEPTH;
	localparam int ST = NB * SPB;
	localparam int LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #2 clk = ~clk;

	hkst_chan_if #(.T(req_t)) req_ch ();
	hkst_chan_if #(.T(rsp_t)) rsp_ch ();
	hkst_chan_if #(.T(bucket_count_t)) cfg_ch ();

	hashed_key_stack_table_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source),
		.cfg(cfg_ch.sink)
	);

	// Shadow copy of the table.
	bucket_count_t shadow_bc;
	logic [KEY_W-1:0] sh_key [ST];
	bit sh_claimed [ST];
	int sh_top [ST];
	logic [VAL_W-1:0] sh_val [PD];
	int sh_link [PD];
	int sh_free;
	int sh_fresh;

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];
	int errors = 0;
	int cycles = 0;
	bit hold_off = 1'b0;
	int burst_left = 0;
	int gap_left = 0;

	function automatic int bucket_of(logic [KEY_W-1:0] k);
		int n;
		n = shadow_bc;
		if (n == 0) n = 1;
		if (n > NB) n = NB;
		return int'(k % n) * SPB;
	endfunction

	function automatic rsp_t table_step(req_t r);
		rsp_t o;
		int b;
		int s;
		int n;
		o.popped_value = '0;
		o.status = STATUS_OK;
		b = bucket_of(r.key);
		s = -1;
		for (int i = 0; i < SPB; i++)
			if (s < 0 && sh_claimed[b+i] && sh_key[b+i] == r.key) s = b + i;
		if (r.func == FUNC_PUSH) begin
			if (s < 0)
				for (int i = 0; i < SPB; i++)
					if (s < 0 && !sh_claimed[b+i]) s = b + i;
			if (s < 0 || (sh_free >= PD && sh_fresh >= PD)) begin
				o.status = STATUS_FULL;
			end else begin
				if (sh_free < PD) begin
					n = sh_free;
					sh_free = sh_link[n];
				end else begin
					n = sh_fresh;
					sh_fresh++;
				end
				if (!sh_claimed[s]) begin
					sh_claimed[s] = 1'b1;
					sh_key[s] = r.key;
					sh_top[s] = PD;
				end
				sh_val[n] = r.value;
				sh_link[n] = sh_top[s];
				sh_top[s] = n;
			end
		end else begin
			if (s < 0 || sh_top[s] >= PD) begin
				o.status = STATUS_EMPTY;
			end else begin
				n = sh_top[s];
				o.popped_value = sh_val[n];
				sh_top[s] = sh_link[n];
				sh_link[n] = sh_free;
				sh_free = n;
			end
		end
		return o;
	endfunction

	function automatic req_t mk(logic f, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
		req_t r;
		r.func = f;
		r.key = k;
		r.value = v;
		return r;
	endfunction

	// Driver: bursts of items separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (!req_ch.valid || req_ch.ready) begin
				if (req_ch.valid) expected_rsps.push_back(table_step(req_ch.data));
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req_ch.valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					req_ch.valid <= 1'b1;
					req_ch.data <= pending_reqs.pop_front();
					if (burst_left == 0) begin
						burst_left <= $urandom_range(20, 1);
						gap_left <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(60, 0);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor and receiver stall pattern.
	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			cycles <= cycles + 1;
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsps.size() == 0) begin
					$error("result with no expected item: %p", rsp_ch.data);
					errors <= errors + 1;
				end else begin
					exp_rsp = expected_rsps.pop_front();
					if (rsp_ch.data.popped_value !== exp_rsp.popped_value) begin
						$error("popped_value expected %0d actual %0d",
							exp_rsp.popped_value, rsp_ch.data.popped_value);
						errors <= errors + 1;
					end
					if (rsp_ch.data.status !== exp_rsp.status) begin
						$error("status expected %0d actual %0d",
							exp_rsp.status, rsp_ch.data.status);
						errors <= errors + 1;
					end
				end
			end
			if (hold_off) rsp_ch.ready <= 1'b0;
			else if (cycles % 512 < 128) rsp_ch.ready <= 1'b1;
			else rsp_ch.ready <= ($urandom_range(3, 0) != 0);
			if (cycles > LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic drain();
		while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_bucket_count(bucket_count_t v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		shadow_bc = v;
	endtask

	// Well-formed traffic on a small set of keys so stacks grow and shrink.
	task automatic add_random(int count, int key_span);
		logic [KEY_W-1:0] k;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9, 0) == 0) k = $urandom();
			else k = $urandom_range(key_span, 0);
			if ($urandom_range(7, 0) == 0) k = k | 32'hFFFF_0000;
			pending_reqs.push_back(mk($urandom_range(1, 0) == 1 ? FUNC_POP : FUNC_PUSH,
				k, $urandom()));
		end
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		shadow_bc = bucket_count_t'(BC_RESET);
		for (int i = 0; i < ST; i++) sh_claimed[i] = 1'b0;
		sh_free = PD;
		sh_fresh = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extremes, empty pops, bucket full, LIFO order.
		pending_reqs.push_back(mk(FUNC_POP, 32'd5, 32'd0));
		pending_reqs.push_back(mk(FUNC_PUSH, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
		pending_reqs.push_back(mk(FUNC_PUSH, 32'hFFFF_FFFF, 32'h8000_0000));
		pending_reqs.push_back(mk(FUNC_PUSH, 32'd0, 32'hFFFF_FFFF));
		pending_reqs.push_back(mk(FUNC_POP, 32'hFFFF_FFFF, 32'h1234_5678));
		pending_reqs.push_back(mk(FUNC_POP, 32'hFFFF_FFFF, 32'd0));
		pending_reqs.push_back(mk(FUNC_POP, 32'hFFFF_FFFF, 32'd0));
		pending_reqs.push_back(mk(FUNC_POP, 32'd0, 32'd0));
		for (int i = 0; i < 5; i++)
			pending_reqs.push_back(mk(FUNC_PUSH, 32'd3 + 64 * i, i));
		pending_reqs.push_back(mk(FUNC_POP, 32'd3 + 64 * 4, 32'd0));
		pending_reqs.push_back(mk(FUNC_POP, 32'd3 + 128, 32'd0));
		drain();

		// Long receiver hold-off while the sender keeps offering items.
		add_random(40, 200);
		hold_off = 1'b1;
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
		add_random(100, 300);
		drain();

		// Bucket count changes, extremes included; zero acts as one.
		write_bucket_count(7'd1);
		add_random(150, 40);
		drain();
		write_bucket_count(7'd0);
		add_random(100, 40);
		drain();
		write_bucket_count(7'd127);
		add_random(100, 500);
		drain();
		write_bucket_count(7'd13);
		add_random(100, 100);
		drain();

		// Exhaust the pool: 64 buckets of 4 keys each, 4 or 5 pushes per key.
		write_bucket_count(7'd64);
		for (int i = 0; i < 1100; i++)
			pending_reqs.push_back(mk(FUNC_PUSH, i % 256, $urandom()));
		add_random(120, 300);
		drain();

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
